/* design/anss_pkg.sv */
package anss_pkg;

  // Field widths of the item channels
  localparam int KIND_W    = 2;
  localparam int COORD_W   = 24;
  localparam int NOISE_W   = 16;
  localparam int UNIFORM_W = 16;
  localparam int VALUE_W   = 32;
  localparam int COUNT_W   = 24;
  localparam int EXP_W     = 17;

  // Item kinds; the fourth code is unused and leaves the state alone
  localparam logic [KIND_W-1:0] KIND_START  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ANNEAL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

  localparam logic [COUNT_W-1:0] STEP_COUNT_RESET = 24'd1000000;

  // Shared multiplier operand and product widths
  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 31;
  localparam int MUL_P_W = 56;

  // Objective f = 0.26*(x^2+y^2) - 0.48*x*y, kept as integers over 100
  localparam logic signed [MUL_B_W-1:0] OBJ_SQ_C     = 31'sd26;
  localparam logic signed [MUL_B_W-1:0] OBJ_XY_C     = 31'sd48;
  localparam logic signed [MUL_B_W-1:0] ACCEPT_SCALE = 31'sd10000;

  // Neighbour step: round(noise * 2^F / 409600), 409600 = 25 * 2^14
  localparam int NOISE_HALF  = 204800;
  localparam int NOISE_SHIFT = 14;

  // Divide-by-25 unit, one byte of quotient per cycle
  localparam int DIV_BASE        = 25;
  localparam int DIV_RECIP       = 10486;
  localparam int DIV_RECIP_W     = 14;
  localparam int DIV_RECIP_SHIFT = 18;
  localparam int DIV_DIGIT_W     = 8;
  localparam int DIV_REM_W       = 5;

  localparam int LHS_W = 30;
  localparam int RHS_W = 41;

  typedef struct packed {
    logic [KIND_W-1:0]           kind;
    logic signed [COORD_W-1:0]   point_x;
    logic signed [COORD_W-1:0]   point_y;
    logic signed [NOISE_W-1:0]   noise_x;
    logic signed [NOISE_W-1:0]   noise_y;
    logic [UNIFORM_W-1:0]        uniform_draw;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] cur_x;
    logic signed [COORD_W-1:0] cur_y;
    logic [VALUE_W-1:0]        best_value;
    logic                      moved;
    logic                      final_res;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NOISE_X,
    ST_NOISE_Y,
    ST_PREP,
    ST_MUL_X,
    ST_MUL_Y,
    ST_SUM,
    ST_OBJ_DIV,
    ST_DECIDE,
    ST_MUL_K,
    ST_ACCEPT,
    ST_DONE
  } state_t;

endpackage

/* design/anss_mul.sv */
module anss_mul (
  input  logic                                 clk,
  input  logic signed [anss_pkg::MUL_A_W-1:0]  a,
  input  logic signed [anss_pkg::MUL_B_W-1:0]  b,
  output logic signed [anss_pkg::MUL_P_W-1:0]  p
);

  // Registered signed product, one per cycle
  always_ff @(posedge clk) begin
    p <= anss_pkg::MUL_P_W'(a) * anss_pkg::MUL_P_W'(b);
  end

endmodule

/* design/anss_div.sv */
module anss_div #(
  parameter int DIV_W = 35
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  output logic [DIV_W-1:0] quotient,
  output logic             done
);

  localparam int DGW = anss_pkg::DIV_DIGIT_W;
  localparam int NB  = (DIV_W + DGW - 1) / DGW;
  localparam int PW  = NB * DGW;
  localparam int CW  = $clog2(NB + 1);
  localparam int VW  = anss_pkg::DIV_REM_W + DGW;
  localparam int RW  = VW + anss_pkg::DIV_RECIP_W;

  logic [PW-1:0]                  sh;
  logic [anss_pkg::DIV_REM_W-1:0] rem;
  logic [CW-1:0]                  cnt;
  logic                           busy;
  logic [VW-1:0]                  v;
  logic [RW-1:0]                  rp;
  logic [DGW-1:0]                 d;
  logic [VW-1:0]                  r;

  // One byte of quotient: partial remainder stays below 25, so the
  // reciprocal estimate is exact over the whole 13-bit range
  always_comb begin
    v  = {rem, sh[PW-1 -: DGW]};
    rp = RW'(v) * RW'(anss_pkg::DIV_RECIP);
    d  = rp[anss_pkg::DIV_RECIP_SHIFT +: DGW];
    r  = v - VW'(d) * VW'(anss_pkg::DIV_BASE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NB);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift dividend bytes out at the top, quotient bytes in at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= PW'(dividend);
      rem <= '0;
    end else if (busy) begin
      sh  <= {sh[PW-DGW-1:0], d};
      rem <= r[anss_pkg::DIV_REM_W-1:0];
    end
  end

  assign quotient = sh[DIV_W-1:0];

endmodule

/* design/anss_seq.sv */
module anss_seq #(
  parameter int FRAC_BITS       = 16,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [anss_pkg::COUNT_W-1:0]    step_count,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  anss_pkg::in_item_t              in_data,
  output logic                            res_valid,
  input  logic                            res_ready,
  output anss_pkg::out_item_t             res_data
);

  localparam int CRW     = anss_pkg::COORD_W;
  localparam int OBJ_W   = 51 - FRAC_BITS;
  localparam int NDIV_W  = FRAC_BITS + 3;
  localparam int DIV_W   = (OBJ_W > NDIV_W) ? OBJ_W : NDIV_W;
  localparam int QW      = FRAC_BITS + 2;
  localparam int SW      = ((QW + 1 > CRW) ? QW + 1 : CRW) + 1;
  localparam int TW      = FRAC_BITS + 17;
  localparam int VX      = (DIV_W > anss_pkg::VALUE_W) ? DIV_W : anss_pkg::VALUE_W + 1;
  localparam int IW      = $clog2(EXP_TABLE_DEPTH);
  localparam int EW      = FRAC_BITS + 5 + IW;
  localparam logic [63:0] EXP_H = (64'd1 << 36) / EXP_TABLE_DEPTH;

  typedef logic [anss_pkg::EXP_W-1:0] exp_rom_t [EXP_TABLE_DEPTH];

  // exp(-diff) over [0,16) in Q1.16, built from a Q0.32 Taylor base
  function automatic exp_rom_t build_exp_rom(input logic [63:0] h);
    logic [63:0] term;
    logic [63:0] base;
    logic [63:0] acc;
    exp_rom_t    rom;
    term = 64'h1_0000_0000;
    base = term;
    acc  = term;
    for (int n = 1; n <= 15; n++) begin
      term = ((term * h) >> 32) / 64'(n);
      if ((n & 1) == 1) begin
        base = base - term;
      end else begin
        base = base + term;
      end
    end
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      rom[i] = anss_pkg::EXP_W'((acc + 64'h8000) >> 16);
      acc    = (acc * base) >> 32;
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom(EXP_H);

  function automatic logic [DIV_W-1:0] noise_div_in(input logic signed [anss_pkg::NOISE_W-1:0] nz);
    logic [anss_pkg::NOISE_W-1:0] mag;
    logic [TW-1:0]                t;
    mag = nz[anss_pkg::NOISE_W-1] ? anss_pkg::NOISE_W'(-nz) : anss_pkg::NOISE_W'(nz);
    t   = (TW'(mag) << FRAC_BITS) + TW'(anss_pkg::NOISE_HALF);
    return DIV_W'(t >> anss_pkg::NOISE_SHIFT);
  endfunction

  function automatic logic signed [CRW-1:0] step_coord(input logic signed [CRW-1:0] c,
                                                       input logic neg,
                                                       input logic [QW-1:0] q);
    logic signed [SW-1:0] cw;
    logic signed [SW-1:0] qw;
    logic signed [SW-1:0] s;
    cw = SW'(c);
    qw = $signed(SW'(q));
    s  = neg ? cw - qw : cw + qw;
    if ((&s[SW-1:CRW-1]) || !(|s[SW-1:CRW-1])) begin
      return s[CRW-1:0];
    end
    return s[SW-1] ? anss_pkg::COORD_MIN : anss_pkg::COORD_MAX;
  endfunction

  function automatic logic [anss_pkg::VALUE_W-1:0] obj_value(input logic [DIV_W-1:0] q);
    logic [VX-1:0] qw;
    qw = VX'(q);
    if (|qw[VX-1:anss_pkg::VALUE_W]) begin
      return '1;
    end
    return qw[anss_pkg::VALUE_W-1:0];
  endfunction

  function automatic logic [anss_pkg::EXP_W-1:0] exp_lookup(input logic [anss_pkg::VALUE_W-1:0] diff);
    logic [EW-1:0] ep;
    ep = EW'(diff[FRAC_BITS+3:0]) * EW'(EXP_TABLE_DEPTH);
    if (|diff[anss_pkg::VALUE_W-1:FRAC_BITS+4]) begin
      return '0;
    end
    return EXP_ROM[ep[FRAC_BITS+4 +: IW]];
  endfunction

  anss_pkg::state_t state;
  anss_pkg::state_t state_next;

  anss_pkg::in_item_t                      item;
  logic signed [CRW-1:0]                   cur_x;
  logic signed [CRW-1:0]                   cur_y;
  logic [anss_pkg::VALUE_W-1:0]            best_val;
  logic [anss_pkg::COUNT_W-1:0]            anneal_index;
  logic [anss_pkg::COUNT_W-1:0]            search_index;
  logic signed [CRW-1:0]                   px;
  logic signed [CRW-1:0]                   py;
  logic [QW-1:0]                           qx;
  logic signed [anss_pkg::MUL_B_W-1:0]     fa;
  logic signed [anss_pkg::MUL_B_W-1:0]     fb;
  logic signed [anss_pkg::MUL_P_W-1:0]     acc;
  logic [anss_pkg::VALUE_W-1:0]            nv;
  logic [anss_pkg::EXP_W-1:0]              exp_val;
  logic [anss_pkg::LHS_W-1:0]              lhs;
  logic                                    moved;
  logic                                    fin;

  logic                                    div_start;
  logic [DIV_W-1:0]                        div_in;
  logic [DIV_W-1:0]                        div_q;
  logic                                    div_done;
  logic signed [anss_pkg::MUL_A_W-1:0]     mul_a;
  logic signed [anss_pkg::MUL_B_W-1:0]     mul_b;
  logic signed [anss_pkg::MUL_P_W-1:0]     mul_p;
  logic signed [anss_pkg::MUL_P_W-1:0]     obj_sum;
  logic [anss_pkg::MUL_P_W-1:0]            obj_pos;
  logic                                    better;

  anss_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  anss_div #(
    .DIV_W (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_in),
    .quotient (div_q),
    .done     (div_done)
  );

  // 100*f*2^2F is x*(26x-48y) + y*(26y); never negative, clamp anyway
  always_comb begin
    obj_sum = acc + mul_p;
    obj_pos = obj_sum[anss_pkg::MUL_P_W-1] ? '0 : obj_sum;
    better  = nv < best_val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= anss_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    div_start  = 1'b0;
    div_in     = '0;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      anss_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_data.kind)
            anss_pkg::KIND_START, anss_pkg::KIND_SEARCH: begin
              state_next = anss_pkg::ST_PREP;
            end
            anss_pkg::KIND_ANNEAL: begin
              div_start  = 1'b1;
              div_in     = noise_div_in(in_data.noise_x);
              state_next = anss_pkg::ST_NOISE_X;
            end
            default: begin
              state_next = anss_pkg::ST_DONE;
            end
          endcase
        end
      end
      anss_pkg::ST_NOISE_X: begin
        if (div_done) begin
          div_start  = 1'b1;
          div_in     = noise_div_in(item.noise_y);
          state_next = anss_pkg::ST_NOISE_Y;
        end
      end
      anss_pkg::ST_NOISE_Y: begin
        if (div_done) begin
          state_next = anss_pkg::ST_PREP;
        end
      end
      anss_pkg::ST_PREP: begin
        state_next = anss_pkg::ST_MUL_X;
      end
      anss_pkg::ST_MUL_X: begin
        mul_a      = anss_pkg::MUL_A_W'(px);
        mul_b      = fa;
        state_next = anss_pkg::ST_MUL_Y;
      end
      anss_pkg::ST_MUL_Y: begin
        mul_a      = anss_pkg::MUL_A_W'(py);
        mul_b      = fb;
        state_next = anss_pkg::ST_SUM;
      end
      anss_pkg::ST_SUM: begin
        div_start  = 1'b1;
        div_in     = DIV_W'(obj_pos >> (FRAC_BITS + 2));
        state_next = anss_pkg::ST_OBJ_DIV;
      end
      anss_pkg::ST_OBJ_DIV: begin
        if (div_done) begin
          state_next = anss_pkg::ST_DECIDE;
        end
      end
      anss_pkg::ST_DECIDE: begin
        if (item.kind == anss_pkg::KIND_ANNEAL && !better) begin
          mul_a      = anss_pkg::MUL_A_W'($signed({1'b0, item.uniform_draw}));
          mul_b      = anss_pkg::ACCEPT_SCALE;
          state_next = anss_pkg::ST_MUL_K;
        end else begin
          state_next = anss_pkg::ST_DONE;
        end
      end
      anss_pkg::ST_MUL_K: begin
        mul_a      = $signed({1'b0, anneal_index});
        mul_b      = anss_pkg::MUL_B_W'($signed({1'b0, exp_val}));
        state_next = anss_pkg::ST_ACCEPT;
      end
      anss_pkg::ST_ACCEPT: begin
        state_next = anss_pkg::ST_DONE;
      end
      anss_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = anss_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = anss_pkg::ST_IDLE;
      end
    endcase
  end

  // Search state: current point, best value and the two step counters
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x        <= '0;
      cur_y        <= '0;
      best_val     <= '1;
      anneal_index <= '0;
      search_index <= '0;
    end else begin
      case (state)
        anss_pkg::ST_DECIDE: begin
          case (item.kind)
            anss_pkg::KIND_START: begin
              cur_x        <= px;
              cur_y        <= py;
              best_val     <= nv;
              anneal_index <= '0;
              search_index <= '0;
            end
            anss_pkg::KIND_SEARCH: begin
              if (better) begin
                cur_x    <= px;
                cur_y    <= py;
                best_val <= nv;
              end
              search_index <= search_index + 1'b1;
            end
            anss_pkg::KIND_ANNEAL: begin
              if (better) begin
                cur_x        <= px;
                cur_y        <= py;
                best_val     <= nv;
                anneal_index <= anneal_index + 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        anss_pkg::ST_ACCEPT: begin
          if (anss_pkg::RHS_W'(lhs) < mul_p[anss_pkg::RHS_W-1:0]) begin
            cur_x <= px;
            cur_y <= py;
          end
          anneal_index <= anneal_index + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      anss_pkg::ST_IDLE: begin
        if (in_valid) begin
          item  <= in_data;
          px    <= in_data.point_x;
          py    <= in_data.point_y;
          moved <= 1'b0;
          fin   <= 1'b0;
        end
      end
      anss_pkg::ST_NOISE_X: begin
        if (div_done) begin
          qx <= div_q[QW-1:0];
        end
      end
      anss_pkg::ST_NOISE_Y: begin
        if (div_done) begin
          px <= step_coord(cur_x, item.noise_x[anss_pkg::NOISE_W-1], qx);
          py <= step_coord(cur_y, item.noise_y[anss_pkg::NOISE_W-1], div_q[QW-1:0]);
        end
      end
      anss_pkg::ST_PREP: begin
        fa <= anss_pkg::MUL_B_W'(px) * anss_pkg::OBJ_SQ_C
              - anss_pkg::MUL_B_W'(py) * anss_pkg::OBJ_XY_C;
        fb <= anss_pkg::MUL_B_W'(py) * anss_pkg::OBJ_SQ_C;
      end
      anss_pkg::ST_MUL_Y: begin
        acc <= mul_p;
      end
      anss_pkg::ST_OBJ_DIV: begin
        if (div_done) begin
          nv <= obj_value(div_q);
        end
      end
      anss_pkg::ST_DECIDE: begin
        case (item.kind)
          anss_pkg::KIND_START: begin
            moved <= 1'b1;
          end
          anss_pkg::KIND_SEARCH: begin
            moved <= better;
            fin   <= (search_index + 1'b1) == step_count;
          end
          anss_pkg::KIND_ANNEAL: begin
            moved   <= better;
            exp_val <= exp_lookup(nv - best_val);
          end
          default: begin
          end
        endcase
      end
      anss_pkg::ST_MUL_K: begin
        lhs <= mul_p[anss_pkg::LHS_W-1:0];
      end
      anss_pkg::ST_ACCEPT: begin
        moved <= anss_pkg::RHS_W'(lhs) < mul_p[anss_pkg::RHS_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_data.cur_x      = cur_x;
    res_data.cur_y      = cur_y;
    res_data.best_value = best_val;
    res_data.moved      = moved;
    res_data.final_res  = fin;
  end

endmodule

/* design/annealing_search_step_top.sv */
// Annealing search step on the Matyas objective, fixed point.
// Input channel (in_valid/in_ready/in_data) takes one item per transfer:
// a start item places the point and best value, an anneal item steps the
// point by 0.01 times the supplied normal noise, a search item tries a drawn
// point. Every item yields exactly one result on out_valid/out_ready/out_data.
// Config channel (cfg_valid/cfg_ready/cfg_data) writes step_count; always ready.
// Start and search items evaluate the objective through the multiplier and
// the divide-by-25 unit; anneal items first divide both noise values, and a
// worse neighbour also goes through the acceptance test; an unused kind goes
// straight to its result.
// One item is worked on at a time, through the shared 25x31 multiplier and
// the serial divider. in_ready is high only while idle.
// A finished result moves into the output register, so the next item can
// be taken while the receiver stalls; with the register full the sequencer
// holds its result until out_ready frees it.
// Reset: point at zero, best value all ones, counters zero, step_count
// 1000000, output register empty.
module annealing_search_step_top #(
  parameter int FRAC_BITS       = 16,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  anss_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output anss_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [anss_pkg::COUNT_W-1:0]  cfg_data
);

  logic [anss_pkg::COUNT_W-1:0] step_count;
  logic                         res_valid;
  logic                         res_ready;
  anss_pkg::out_item_t          res_data;

  // Only write configuration while idle; not enforced, every transfer is taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_count <= anss_pkg::STEP_COUNT_RESET;
    end else if (cfg_valid) begin
      step_count <= cfg_data;
    end
  end

  anss_seq #(
    .FRAC_BITS       (FRAC_BITS),
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .step_count (step_count),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_data   (res_data)
  );

  // Output register: load when empty or draining this cycle
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Hold the payload until the transfer completes
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data <= res_data;
    end
  end

endmodule

/* tb/annealing_search_step_checker.sv */
`timescale 1ns / 1ps

module annealing_search_step_checker #(
  parameter int FRAC_BITS       = 16,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  anss_pkg::in_item_t            in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  anss_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [anss_pkg::COUNT_W-1:0]  cfg_data,
  input  logic                          run_over,
  output int                            fail_count,
  output int                            checked_count,
  output int                            moved_count,
  output int                            flagged_count
);
  import anss_pkg::*;

  logic [COUNT_W-1:0]        step_count_q;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic [VALUE_W-1:0]        best_q;
  logic [COUNT_W-1:0]        anneal_k;
  logic [COUNT_W-1:0]        search_k;
  logic [EXP_W-1:0]          decay_rom [EXP_TABLE_DEPTH];
  out_item_t                 awaited_results [$];
  logic                      closed = 1'b0;

  // exp(-diff) over [0,16) in Q1.16, built from a Q0.32 Taylor base
  initial begin
    longint unsigned h;
    longint unsigned term;
    longint unsigned base;
    longint unsigned acc;
    h    = (64'd16 << 32) / EXP_TABLE_DEPTH;
    term = 64'd1 << 32;
    base = term;
    acc  = term;
    for (int n = 1; n <= 15; n++) begin
      term = ((term * h) >> 32) / n;
      if (n % 2)
        base = base - term;
      else
        base = base + term;
    end
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      decay_rom[i] = EXP_W'((acc + 64'h8000) >> 16);
      acc = (acc * base) >> 32;
    end
  end

  function automatic logic [VALUE_W-1:0] matyas_value(logic signed [COORD_W-1:0] x,
                                                      logic signed [COORD_W-1:0] y);
    longint sx;
    longint sy;
    longint n;
    longint v;
    sx = x;
    sy = y;
    n = 26 * (sx * sx + sy * sy) - 48 * (sx * sy);
    if (n < 0)
      n = 0;
    v = (n / 100) >>> FRAC_BITS;
    if (v > 64'hFFFF_FFFF)
      return '1;
    return v[VALUE_W-1:0];
  endfunction

  // 0.01 * noise in coordinate units, rounded half away from zero
  function automatic longint noise_delta(logic signed [NOISE_W-1:0] noise);
    longint num;
    longint unsigned mag;
    longint q;
    num = longint'(noise) * (longint'(1) << FRAC_BITS);
    mag = (num < 0) ? -num : num;
    q = (mag + NOISE_HALF) / (2 * NOISE_HALF);
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic signed [COORD_W-1:0] clamp_coord(longint v);
    if (v > longint'(COORD_MAX))
      return COORD_MAX;
    if (v < longint'(COORD_MIN))
      return COORD_MIN;
    return v[COORD_W-1:0];
  endfunction

  function automatic longint unsigned decay_weight(logic [VALUE_W-1:0] diff);
    longint unsigned idx;
    if (64'(diff) >= (64'd16 << FRAC_BITS))
      return 0;
    idx = (64'(diff) * EXP_TABLE_DEPTH) >> (FRAC_BITS + 4);
    if (idx >= EXP_TABLE_DEPTH)
      return 0;
    return 64'(decay_rom[idx]);
  endfunction

  // Apply one item to the search state and return the result it yields
  function automatic out_item_t advance_search(in_item_t item);
    out_item_t r;
    logic signed [COORD_W-1:0] nx;
    logic signed [COORD_W-1:0] ny;
    logic [VALUE_W-1:0] nv;
    longint unsigned lhs;
    longint unsigned rhs;
    r = '0;
    case (item.kind)
      KIND_START: begin
        pos_x = item.point_x;
        pos_y = item.point_y;
        best_q = matyas_value(pos_x, pos_y);
        anneal_k = '0;
        search_k = '0;
        r.moved = 1'b1;
      end
      KIND_ANNEAL: begin
        nx = clamp_coord(longint'(pos_x) + noise_delta(item.noise_x));
        ny = clamp_coord(longint'(pos_y) + noise_delta(item.noise_y));
        nv = matyas_value(nx, ny);
        if (nv < best_q) begin
          best_q = nv;
          r.moved = 1'b1;
        end else begin
          lhs = 64'(item.uniform_draw) * 64'(ACCEPT_SCALE);
          rhs = decay_weight(nv - best_q) * 64'(anneal_k);
          r.moved = (lhs < rhs);
        end
        if (r.moved) begin
          pos_x = nx;
          pos_y = ny;
        end
        anneal_k = anneal_k + 1'b1;
      end
      KIND_SEARCH: begin
        nv = matyas_value(item.point_x, item.point_y);
        if (nv < best_q) begin
          best_q = nv;
          pos_x = item.point_x;
          pos_y = item.point_y;
          r.moved = 1'b1;
        end
        r.final_res = ((search_k + 1'b1) == step_count_q);
        search_k = search_k + 1'b1;
      end
      default: ;
    endcase
    r.cur_x = pos_x;
    r.cur_y = pos_y;
    r.best_value = best_q;
    return r;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      step_count_q = STEP_COUNT_RESET;
      pos_x = '0;
      pos_y = '0;
      best_q = '1;
      anneal_k = '0;
      search_k = '0;
      awaited_results.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        step_count_q = cfg_data;
      // Retire the result before queuing the new item's expectation
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $error("result transfer with no result expected");
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("cur_x", longint'(want.cur_x), longint'(out_data.cur_x));
          check_field("cur_y", longint'(want.cur_y), longint'(out_data.cur_y));
          check_field("best_value", 64'(want.best_value), 64'(out_data.best_value));
          check_field("moved", 64'(want.moved), 64'(out_data.moved));
          check_field("final_res", 64'(want.final_res), 64'(out_data.final_res));
          checked_count++;
          moved_count += out_data.moved;
          flagged_count += out_data.final_res;
        end
      end
      if (in_valid && in_ready)
        awaited_results.push_back(advance_search(in_data));
      if (run_over && !closed) begin
        closed = 1'b1;
        if (awaited_results.size() != 0) begin
          $error("%0d expected results never arrived", awaited_results.size());
          fail_count += awaited_results.size();
        end
      end
    end
  end

endmodule

/* tb/annealing_search_step_top_test.sv */
`timescale 1ns / 1ps

module annealing_search_step_top_test;
  import anss_pkg::*;

  // The package names three kinds; the fourth code must leave state alone
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam int IDLE_PCT        = 22;
  localparam int HOLD_OFF_CYCLES = 400;
  // Longest quiet stretch of a correct run is the receiver hold-off plus
  // one slow anneal item; allow several times that.
  localparam int STALL_LIMIT     = 2000;
  localparam int DRAIN_CYCLES    = 40;
  localparam int RANDOM_ITEMS    = 880;

  localparam logic signed [COORD_W-1:0] UNIT      = 24'sd65536;
  localparam logic signed [COORD_W-1:0] NEAR_EDGE = 24'sd7864320;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [COUNT_W-1:0]  cfg_data  = '0;
  logic                run_over  = 1'b0;

  int fail_count;
  int checked_count;
  int moved_count;
  int flagged_count;

  int items_accepted   = 0;
  int settings_written = 0;
  int kind_tally [4]   = '{0, 0, 0, 0};
  int sender_idle_pct  = IDLE_PCT;
  int recv_idle_pct    = IDLE_PCT;
  bit hold_off_due     = 1'b0;

  always #4 clk = ~clk;

  annealing_search_step_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  annealing_search_step_checker search_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .run_over      (run_over),
    .fail_count    (fail_count),
    .checked_count (checked_count),
    .moved_count   (moved_count),
    .flagged_count (flagged_count)
  );

  // Coordinates over spans from 2^8 LSBs up to the full Q7.16 range
  function automatic logic signed [COORD_W-1:0] draw_coord();
    int span;
    int v;
    span = 1 << $urandom_range(8, 23);
    v = int'($urandom_range(2 * span - 1)) - span;
    return v[COORD_W-1:0];
  endfunction

  // Noise over spans from 2^4 LSBs up to the full Q3.12 range
  function automatic logic signed [NOISE_W-1:0] draw_noise();
    int span;
    int v;
    span = 1 << $urandom_range(4, 15);
    v = int'($urandom_range(2 * span - 1)) - span;
    return v[NOISE_W-1:0];
  endfunction

  function automatic in_item_t make_item(logic [KIND_W-1:0] kind,
                                         logic signed [COORD_W-1:0] px,
                                         logic signed [COORD_W-1:0] py,
                                         logic signed [NOISE_W-1:0] nx,
                                         logic signed [NOISE_W-1:0] ny,
                                         logic [UNIFORM_W-1:0] u);
    in_item_t item;
    item.kind         = kind;
    item.point_x      = px;
    item.point_y      = py;
    item.noise_x      = nx;
    item.noise_y      = ny;
    item.uniform_draw = u;
    return item;
  endfunction

  // Fill every field, the ones the kind ignores too; keep uniform draws
  // small half the time so the acceptance test passes now and then
  function automatic in_item_t random_item(logic [KIND_W-1:0] kind);
    logic [UNIFORM_W-1:0] u;
    u = $urandom_range(1) ? UNIFORM_W'($urandom_range(1023)) : UNIFORM_W'($urandom);
    return make_item(kind, draw_coord(), draw_coord(), draw_noise(), draw_noise(), u);
  endfunction

  // Offer one item, idling first at random; leave valid high on return so
  // a back-to-back item needs only one assignment in that step
  task automatic send_item(input in_item_t item);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    items_accepted++;
    kind_tally[item.kind]++;
  endtask

  // Drop valid and hold until every accepted item has its result checked
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (checked_count != items_accepted)
      @(posedge clk);
  endtask

  task automatic write_step_count(input logic [COUNT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    cfg_valid <= 1'b0;
    settings_written++;
  endtask

  // One start, then a walk of anneal, search, unused-kind and start items
  task automatic run_walk();
    int steps;
    int roll;
    steps = $urandom_range(5, 40);
    send_item(random_item(KIND_START));
    repeat (steps) begin
      roll = $urandom_range(99);
      if (roll < 72)
        send_item(random_item(KIND_ANNEAL));
      else if (roll < 94)
        send_item(random_item(KIND_SEARCH));
      else if (roll < 97)
        send_item(random_item(KIND_UNUSED));
      else
        send_item(random_item(KIND_START));
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request, counted here
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_due) begin
        hold_off_due = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES)
          @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: end the run when no transfer of any kind happens for too long
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $error("no transfer for %0d cycles, stopping", STALL_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic [COUNT_W-1:0] walk_steps [4];
    int phase_target;

    // Max register value never flags, the small ones flag inside a walk
    walk_steps[0] = 24'hFFFFFF;
    walk_steps[1] = 24'd4;
    walk_steps[2] = COUNT_W'($urandom_range(2, 12));
    walk_steps[3] = 24'd1;

    repeat (6)
      @(posedge clk);
    rst <= 1'b0;

    // Before any start the best value is all ones, so anything is better;
    // step_count still holds its reset value here
    send_item(make_item(KIND_UNUSED, '0, '0, '0, '0, '0));
    send_item(make_item(KIND_ANNEAL, '0, '0, 16'sd1000, -16'sd1000, '0));
    send_item(make_item(KIND_SEARCH, UNIT, -UNIT, '0, '0, '0));
    send_item(make_item(KIND_SEARCH, '0, '0, '0, '0, '0));
    wait_for_results();

    // Smallest step count: the first search after a start is the last one
    write_step_count(24'd1);
    send_item(make_item(KIND_START, '0, '0, '0, '0, '0));
    send_item(make_item(KIND_SEARCH, UNIT, UNIT, '0, '0, '0));
    send_item(make_item(KIND_SEARCH, '0, '0, '0, '0, '0));
    // Corners: the neighbour step saturates at both ends of the range
    send_item(make_item(KIND_START, COORD_MAX, COORD_MAX, '0, '0, '0));
    send_item(make_item(KIND_ANNEAL, '0, '0, 16'sh7FFF, 16'sh7FFF, 16'hFFFF));
    send_item(make_item(KIND_START, COORD_MIN, COORD_MIN, '0, '0, '0));
    send_item(make_item(KIND_ANNEAL, '0, '0, 16'sh8000, 16'sh8000, '0));
    // Largest objective; at step zero even an equal neighbour is refused,
    // one step later it is taken
    send_item(make_item(KIND_START, COORD_MIN, COORD_MAX, '0, '0, '0));
    send_item(make_item(KIND_ANNEAL, '0, '0, '0, '0, '0));
    send_item(make_item(KIND_ANNEAL, '0, '0, '0, '0, '0));
    send_item(make_item(KIND_ANNEAL, '0, '0, 16'sh7FFF, 16'sh8000, 16'hFFFF));
    // Steep slope: a worse step by 16 or more finds no exp weight at all
    send_item(make_item(KIND_START, NEAR_EDGE, -NEAR_EDGE, '0, '0, '0));
    send_item(make_item(KIND_ANNEAL, '0, '0, '0, '0, '0));
    send_item(make_item(KIND_ANNEAL, '0, '0, 16'sh7FFF, 16'sh8000, '0));
    send_item(make_item(KIND_ANNEAL, '0, '0, 16'sh8000, 16'sh7FFF, '0));
    send_item(make_item(KIND_ANNEAL, '0, '0, 16'sd4096, -16'sd4096, '0));
    send_item(make_item(KIND_SEARCH, '0, '0, '0, '0, '0));
    send_item(make_item(KIND_ANNEAL, '0, '0, 16'sd4096, 16'sd4096, 16'hFFFF));

    // Random walks, one register setting per phase; the second phase runs
    // without idling, the third starts with a long receiver hold-off
    for (int phase = 0; phase < 4; phase++) begin
      wait_for_results();
      write_step_count(walk_steps[phase]);
      sender_idle_pct = (phase == 1) ? 0 : IDLE_PCT;
      recv_idle_pct   = (phase == 1) ? 0 : IDLE_PCT;
      if (phase == 2)
        hold_off_due = 1'b1;
      phase_target = items_accepted + RANDOM_ITEMS / 4;
      while (items_accepted < phase_target)
        run_walk();
    end

    wait_for_results();
    repeat (DRAIN_CYCLES)
      @(posedge clk);
    run_over <= 1'b1;
    repeat (2)
      @(posedge clk);

    $display("Sent %0d items: %0d start, %0d anneal, %0d search, %0d unused kind; %0d step_count writes",
             items_accepted, kind_tally[KIND_START], kind_tally[KIND_ANNEAL],
             kind_tally[KIND_SEARCH], kind_tally[KIND_UNUSED], settings_written);
    $display("Checked %0d results: %0d moved the point, %0d marked the last search step",
             checked_count, moved_count, flagged_count);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

/* files.f */
design/anss_pkg.sv
design/anss_mul.sv
design/anss_div.sv
design/anss_seq.sv
design/annealing_search_step_top.sv
tb/annealing_search_step_checker.sv
tb/annealing_search_step_top_test.sv
